[rtl/epoch_seconds_to_calendar_unit_defines.svh]
// Assertion macros for the checker file of the calendar unit.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_DEFINES_SVH

`define ESCAL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

`define ESCAL_ASSERT_CLK(label, prop) \
  `ESCAL_ASSERT(label, clk_i, rst_ni, prop)

`endif

[rtl/escal_pkg.sv]
package escal_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DAYS_W = 16;
  localparam int unsigned YEAR_W = 8;
  localparam int unsigned YD_W = 9;

  localparam logic [TIME_W-1:0] BASE_RESET = 32'd946684800;

  localparam logic [5:0] SEC_PER_MIN = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR = 6'd60;
  localparam logic [5:0] HOURS_PER_DAY = 6'd24;
  localparam logic [5:0] DAYS_PER_WEEK = 6'd7;

  // Rounded-up reciprocals; the quotient is the product shifted right by the paired amount.
  localparam logic [TIME_W-1:0] RECIP_SIXTY = 32'h8888_8889;
  localparam logic [TIME_W-1:0] RECIP_TWENTY_FOUR = 32'hAAAA_AAAB;
  localparam logic [TIME_W-1:0] RECIP_SEVEN = 32'h2492_4925;
  localparam logic [5:0] SHIFT_SIXTY = 6'd37;
  localparam logic [5:0] SHIFT_TWENTY_FOUR = 6'd36;
  localparam logic [5:0] SHIFT_SEVEN = 6'd32;

  localparam logic [DAYS_W-1:0] WDAY_OFFSET = 16'd6;
  localparam logic [DAYS_W-1:0] DAYS_PER_QUAD = 16'd1461;
  localparam logic [DAYS_W-1:0] DAYS_LEAP_YEAR = 16'd366;
  localparam logic [DAYS_W-1:0] DAYS_COMMON_YEAR = 16'd365;
  localparam logic [YEAR_W-1:0] YEARS_PER_QUAD = 8'd4;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR,
    DIV_WDAY
  } div_sel_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_MUL,
    DP_DIV_STORE,
    DP_YEAR,
    DP_MONTH_INIT,
    DP_MONTH,
    DP_PUBLISH
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_MUL,
    S_DIV_STORE,
    S_YEAR,
    S_MONTH_INIT,
    S_MONTH,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e   op;
    div_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic before_base;
    logic year_done;
    logic month_done;
  } dp_status_t;

  function automatic logic [5:0] div_divisor(div_sel_e sel);
    logic [5:0] d;
    unique case (sel)
      DIV_SEC:  d = SEC_PER_MIN;
      DIV_MIN:  d = MIN_PER_HOUR;
      DIV_HOUR: d = HOURS_PER_DAY;
      DIV_WDAY: d = DAYS_PER_WEEK;
    endcase
    return d;
  endfunction

  function automatic logic [TIME_W-1:0] div_recip(div_sel_e sel);
    logic [TIME_W-1:0] r;
    unique case (sel)
      DIV_SEC:  r = RECIP_SIXTY;
      DIV_MIN:  r = RECIP_SIXTY;
      DIV_HOUR: r = RECIP_TWENTY_FOUR;
      DIV_WDAY: r = RECIP_SEVEN;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] div_post_shift(div_sel_e sel);
    logic [5:0] s;
    unique case (sel)
      DIV_SEC:  s = SHIFT_SIXTY;
      DIV_MIN:  s = SHIFT_SIXTY;
      DIV_HOUR: s = SHIFT_TWENTY_FOUR;
      DIV_WDAY: s = SHIFT_SEVEN;
    endcase
    return s;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m, logic leap);
    logic [4:0] d;
    unique case (m)
      4'd1:                      d = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

[rtl/epoch_seconds_to_calendar_unit.sv]
// The time to a result grows with B, the number of four-year blocks (up to 34), Y the
// remaining years (up to 3) and M the months passed (up to 11); an input before the base
// goes straight to publishing its result.
// Four constant divisions by reciprocal multiplication use a multiply and a store state each.
// One item is in work at a time; publishing waits until the last result is taken.
// Reset sets the base to 2000-01-01 00:00 and leaves no result pending.
module epoch_seconds_to_calendar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        base_seconds_we_i,
  input  logic [31:0] base_seconds_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] epoch_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        valid_res_o,
  output logic [5:0]  second_o,
  output logic [5:0]  minute_o,
  output logic [4:0]  hour_o,
  output logic [2:0]  weekday_o,
  output logic [4:0]  day_of_month_o,
  output logic [3:0]  month_number_o,
  output logic [6:0]  year_offset_o
);
  import escal_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  escal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  escal_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .base_we_i      (base_seconds_we_i),
    .base_i         (base_seconds_i),
    .epoch_i        (epoch_seconds_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .valid_res_o    (valid_res_o),
    .second_o       (second_o),
    .minute_o       (minute_o),
    .hour_o         (hour_o),
    .weekday_o      (weekday_o),
    .day_of_month_o (day_of_month_o),
    .month_number_o (month_number_o),
    .year_offset_o  (year_offset_o)
  );

endmodule

[rtl/escal_dp.sv]
module escal_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  base_we_i,
  input  logic [31:0]           base_i,
  input  logic [31:0]           epoch_i,
  input  escal_pkg::dp_cmd_t    cmd_i,
  output escal_pkg::dp_status_t status_o,
  output logic                  valid_res_o,
  output logic [5:0]            second_o,
  output logic [5:0]            minute_o,
  output logic [4:0]            hour_o,
  output logic [2:0]            weekday_o,
  output logic [4:0]            day_of_month_o,
  output logic [3:0]            month_number_o,
  output logic [6:0]            year_offset_o
);
  import escal_pkg::*;

  logic [TIME_W-1:0] base_q;
  logic [TIME_W-1:0] w_q;
  logic [PROD_W-1:0] prod_q;
  logic              neg_q;
  logic [5:0]        sec_q;
  logic [5:0]        min_q;
  logic [4:0]        hour_q;
  logic [2:0]        wday_q;
  logic [DAYS_W-1:0] days_q;
  logic [YEAR_W-1:0] year_q;
  logic [YD_W-1:0]   yd_q;
  logic [3:0]        mon_q;

  logic              res_valid_q;
  logic [5:0]        res_sec_q;
  logic [5:0]        res_min_q;
  logic [4:0]        res_hour_q;
  logic [2:0]        res_wday_q;
  logic [4:0]        res_day_q;
  logic [3:0]        res_mon_q;
  logic [6:0]        res_year_q;

  logic [5:0]        divisor;
  logic [TIME_W-1:0] div_arg;
  logic [PROD_W-1:0] div_prod;
  logic [PROD_W-1:0] quot_full;
  logic [TIME_W-1:0] quot;
  logic [TIME_W-1:0] quot_x_div;
  logic [TIME_W-1:0] div_rem;
  logic              leap;
  logic [DAYS_W-1:0] year_len;
  logic              quad_ok;
  logic              year_ok;
  logic [4:0]        mlen;
  logic [DAYS_W-1:0] wday_arg;

  assign divisor    = div_divisor(cmd_i.sel);
  assign div_arg    = (cmd_i.sel == DIV_WDAY) ? {{(TIME_W-DAYS_W){1'b0}}, wday_arg} : w_q;
  assign div_prod   = {{(PROD_W-TIME_W){1'b0}}, div_arg} *
                      {{(PROD_W-TIME_W){1'b0}}, div_recip(cmd_i.sel)};
  assign quot_full  = prod_q >> div_post_shift(cmd_i.sel);
  assign quot       = quot_full[TIME_W-1:0];
  assign quot_x_div = quot * {{(TIME_W-6){1'b0}}, divisor};
  assign div_rem    = w_q - quot_x_div;

  assign leap     = year_q[1:0] == 2'b00;
  assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
  assign quad_ok  = days_q >= DAYS_PER_QUAD;
  assign year_ok  = days_q >= year_len;
  assign mlen     = month_days(mon_q, leap);
  assign wday_arg = days_q + WDAY_OFFSET;

  assign status_o.before_base = epoch_i < base_q;
  assign status_o.year_done   = !year_ok;
  assign status_o.month_done  = yd_q <= {{(YD_W-5){1'b0}}, mlen};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_RESET;
    end else if (base_we_i) begin
      base_q <= base_i;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_LOAD: begin
        w_q   <= epoch_i - base_q;
        neg_q <= status_o.before_base;
      end
      DP_DIV_MUL: begin
        prod_q <= div_prod;
        w_q    <= div_arg;
      end
      DP_DIV_STORE: begin
        unique case (cmd_i.sel)
          DIV_SEC: begin
            sec_q <= div_rem[5:0];
            w_q   <= quot;
          end
          DIV_MIN: begin
            min_q <= div_rem[5:0];
            w_q   <= quot;
          end
          DIV_HOUR: begin
            hour_q <= div_rem[4:0];
            days_q <= quot[DAYS_W-1:0];
          end
          DIV_WDAY: begin
            wday_q <= div_rem[2:0];
            year_q <= '0;
          end
        endcase
      end
      DP_YEAR: begin
        if (quad_ok) begin
          days_q <= days_q - DAYS_PER_QUAD;
          year_q <= year_q + YEARS_PER_QUAD;
        end else if (year_ok) begin
          days_q <= days_q - year_len;
          year_q <= year_q + 8'd1;
        end
      end
      DP_MONTH_INIT: begin
        yd_q  <= days_q[YD_W-1:0] + 9'd1;
        mon_q <= '0;
      end
      DP_MONTH: begin
        if (!status_o.month_done) begin
          yd_q  <= yd_q - {{(YD_W-5){1'b0}}, mlen};
          mon_q <= mon_q + 4'd1;
        end
      end
      DP_PUBLISH: begin
        res_valid_q <= !neg_q;
        res_sec_q   <= neg_q ? '0 : sec_q;
        res_min_q   <= neg_q ? '0 : min_q;
        res_hour_q  <= neg_q ? '0 : hour_q;
        res_wday_q  <= neg_q ? '0 : wday_q;
        res_day_q   <= neg_q ? '0 : yd_q[4:0];
        res_mon_q   <= neg_q ? '0 : mon_q + 4'd1;
        res_year_q  <= neg_q ? '0 : year_q[6:0];
      end
      default: begin
      end
    endcase
  end

  assign valid_res_o    = res_valid_q;
  assign second_o       = res_sec_q;
  assign minute_o       = res_min_q;
  assign hour_o         = res_hour_q;
  assign weekday_o      = res_wday_q;
  assign day_of_month_o = res_day_q;
  assign month_number_o = res_mon_q;
  assign year_offset_o  = res_year_q;

endmodule

[rtl/escal_ctrl.sv]
module escal_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  escal_pkg::dp_status_t status_i,
  output escal_pkg::dp_cmd_t    cmd_o
);
  import escal_pkg::*;

  ctrl_state_e      state_q, state_d;
  div_sel_e         sel_q, sel_d;
  logic             out_valid_q, out_valid_d;
  logic             publish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= DIV_SEC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o.op   = DP_NOP;
    cmd_o.sel  = sel_q;
    publish    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          sel_d    = DIV_SEC;
          state_d  = status_i.before_base ? S_FINISH : S_DIV_MUL;
        end
      end
      S_DIV_MUL: begin
        cmd_o.op = DP_DIV_MUL;
        state_d  = S_DIV_STORE;
      end
      S_DIV_STORE: begin
        cmd_o.op = DP_DIV_STORE;
        state_d  = S_DIV_MUL;
        unique case (sel_q)
          DIV_SEC:  sel_d = DIV_MIN;
          DIV_MIN:  sel_d = DIV_HOUR;
          DIV_HOUR: sel_d = DIV_WDAY;
          DIV_WDAY: state_d = S_YEAR;
        endcase
      end
      S_YEAR: begin
        if (status_i.year_done) begin
          state_d = S_MONTH_INIT;
        end else begin
          cmd_o.op = DP_YEAR;
        end
      end
      S_MONTH_INIT: begin
        cmd_o.op = DP_MONTH_INIT;
        state_d  = S_MONTH;
      end
      S_MONTH: begin
        if (status_i.month_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.op = DP_MONTH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = DP_PUBLISH;
          publish  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = publish || (out_valid_q && !out_ready_i);
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

[rtl/escal_chk.sv]
`include "epoch_seconds_to_calendar_unit_defines.svh"

module escal_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o,
  input logic [5:0] second_o,
  input logic [5:0] minute_o,
  input logic [4:0] hour_o,
  input logic [2:0] weekday_o,
  input logic [4:0] day_of_month_o,
  input logic [3:0] month_number_o,
  input logic [6:0] year_offset_o
);

  logic [36:0] fields;
  logic        fields_zero;
  logic        fields_in_range;

  assign fields = {valid_res_o, second_o, minute_o, hour_o, weekday_o,
                   day_of_month_o, month_number_o, year_offset_o};
  assign fields_zero = fields[35:0] == '0;
  assign fields_in_range = (second_o < 6'd60) && (minute_o < 6'd60) &&
                           (hour_o < 5'd24) && (weekday_o < 3'd7) &&
                           (day_of_month_o != 5'd0) && (month_number_o != 4'd0) &&
                           (month_number_o <= 4'd12);

  `ESCAL_ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(fields))
  `ESCAL_ASSERT_CLK(a_early_zero, out_valid_o && !valid_res_o |-> fields_zero)
  `ESCAL_ASSERT_CLK(a_range, out_valid_o && valid_res_o |-> fields_in_range)
  `ESCAL_ASSERT_CLK(a_busy_after_in, in_valid_i && in_ready_o |=> !in_ready_o)

endmodule

bind epoch_seconds_to_calendar_unit escal_chk u_escal_chk (.*);
